// ----- sv/fdr_pkg.sv -----
// Shared constants and types for the Fresnel reflectance pipeline.
// No dependencies; used by fdr_isqrt and fresnel_dielectric_reflectance.
package fdr_pkg;

    localparam int VFB_DEFAULT = 14;

    // Q30 values up to and including one
    localparam int CW  = 31;
    // square root radicand: a Q30 value shifted up by 30
    localparam int SQW = 61;
    // index times sine, Q12 * Q30
    localparam int NW  = 47;
    // index times cosine truncated to Q28
    localparam int XW  = 32;
    // remainder of the ratio divider
    localparam int RW  = 64;

    localparam logic [CW-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [15:0]   IDX_ONE = 16'd4096;
    localparam logic [15:0]   OUT_ONE = 16'd32768;

    typedef struct packed {
        logic          tir;
        logic [15:0]   ei;
        logic [15:0]   et;
        logic [CW-1:0] c;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

// ----- sv/fresnel_dielectric_reflectance.sv -----
// Top level: unpolarized Fresnel reflectance at a dielectric boundary, fully pipelined.
// Depends on fdr_pkg and fdr_isqrt.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, dir_*, norm_*, refraction_index | into block
//  out     | out_valid, out_ready, reflectance, total_internal  | out of block
//
// One item enters per cycle unless the output stalls; items pass through the two 31-stage
// square roots, the 30-stage quotient of Snell's law and the 31-stage ratio dividers.
// Reset clears only the valid bits; no state is kept between items.
// The whole pipeline holds while a result waits at the output register.
module fresnel_dielectric_reflectance #(
    parameter int VECTOR_FRAC_BITS = fdr_pkg::VFB_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic [15:0]        refraction_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        reflectance,
    output logic               total_internal
);
    import fdr_pkg::*;

    localparam int FB2 = 2 * VECTOR_FRAC_BITS;
    localparam logic [63:0] UNIT = 64'd1 << FB2;
    localparam int DSTG = 30;
    localparam int RSTG = CW;

    logic adv;
    logic out_valid_reg;
    logic [15:0] reflectance_reg;
    logic total_internal_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: component products
    logic s1_vld_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [15:0] s1_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg <= dir_x * norm_x;
            s1_py_reg <= dir_y * norm_y;
            s1_pz_reg <= dir_z * norm_z;
            s1_n_reg  <= (refraction_index < IDX_ONE) ? IDX_ONE : refraction_index;
        end
    end

    // ---------------- stage 2: dot product, clamp, swap indices
    logic signed [33:0] s2_dot;
    logic [33:0] s2_mag;
    logic [63:0] s2_wide, s2_clamp, s2_cw;
    logic s2_leaving;
    side_t s2_side_next, s2_side_reg;
    logic s2_vld_reg;

    always_comb
    begin
        s2_dot     = 34'(s1_px_reg) + 34'(s1_py_reg) + 34'(s1_pz_reg);
        s2_mag     = s2_dot[33] ? 34'(-s2_dot) : 34'(s2_dot);
        s2_wide    = {30'b0, s2_mag};
        s2_clamp   = (s2_wide > UNIT) ? UNIT : s2_wide;
        s2_leaving = !s2_dot[33] && (s2_dot != 34'sd0);
    end

    if (FB2 >= 30) begin : g_cdown
        assign s2_cw = s2_clamp >> (FB2 - 30);
    end else begin : g_cup
        assign s2_cw = s2_clamp << (30 - FB2);
    end

    always_comb
    begin
        s2_side_next.tir = 1'b0;
        s2_side_next.ei  = s2_leaving ? s1_n_reg : IDX_ONE;
        s2_side_next.et  = s2_leaving ? IDX_ONE : s1_n_reg;
        s2_side_next.c   = s2_cw[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_side_reg <= s2_side_next;
    end

    // ---------------- stage 3: 1 - cos^2
    logic [61:0] s3_cc;
    logic [CW-1:0] s3_d_next, s3_d_reg;
    side_t s3_side_reg;
    logic s3_vld_reg;

    assign s3_cc     = s2_side_reg.c * s2_side_reg.c;
    assign s3_d_next = Q30_ONE - s3_cc[60:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_d_reg    <= s3_d_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    // ---------------- sin_i
    logic q1_vld;
    logic [CW-1:0] q1_si;
    side_t q1_side;

    fdr_isqrt #(.SIDE_W(SIDE_W)) u_sqrt_sin (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(s3_vld_reg), .rad_hi(s3_d_reg), .side_in(s3_side_reg),
        .out_valid(q1_vld), .root(q1_si), .side_out(q1_side)
    );

    // ---------------- stage 4: etai * sin_i
    logic [NW-1:0] s4_n_next, s4_n_reg;
    side_t s4_side_reg;
    logic s4_vld_reg;

    assign s4_n_next = q1_side.ei * q1_si;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= q1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_n_reg    <= s4_n_next;
            s4_side_reg <= q1_side;
        end
    end

    // ---------------- stage 5: total internal reflection test
    side_t s5_side_next, s5_side_reg;
    logic [NW-1:0] s5_rem_reg;
    logic s5_vld_reg;

    always_comb
    begin
        s5_side_next     = s4_side_reg;
        s5_side_next.tir = s4_n_reg >= {1'b0, s4_side_reg.et, 30'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_rem_reg  <= s4_n_reg;
            s5_side_reg <= s5_side_next;
        end
    end

    // ---------------- sin_t quotient, one bit per stage
    logic [DSTG-1:0] dv_vld_reg;
    logic [NW-1:0]   dv_rem_reg  [DSTG];
    logic [DSTG-1:0] dv_q_reg    [DSTG];
    side_t           dv_side_reg [DSTG];

    genvar j;
    for (j = 0; j < DSTG; j++) begin : g_div
        localparam int K = DSTG - 1 - j;
        localparam logic [DSTG-1:0] Q_BIT = {{(DSTG-1){1'b0}}, 1'b1} << K;

        logic [NW-1:0]   rem_in, dk, rem_next;
        logic [DSTG-1:0] q_in, q_next;
        logic            v_in;
        side_t           s_in;

        if (j == 0) begin : g_first
            assign rem_in = s5_rem_reg;
            assign q_in   = '0;
            assign v_in   = s5_vld_reg;
            assign s_in   = s5_side_reg;
        end else begin : g_rest
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign v_in   = dv_vld_reg[j-1];
            assign s_in   = dv_side_reg[j-1];
        end

        assign dk = {{(NW-16){1'b0}}, s_in.et} << K;

        always_comb
        begin
            if (rem_in >= dk)
            begin
                rem_next = rem_in - dk;
                q_next   = q_in | Q_BIT;
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (adv)
                dv_vld_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_side_reg[j] <= s_in;
            end
        end
    end

    // ---------------- stage 6: 1 - sin_t^2
    logic [59:0] s6_ss;
    logic [CW-1:0] s6_d_next, s6_d_reg;
    side_t s6_side_reg;
    logic s6_vld_reg;

    assign s6_ss     = dv_q_reg[DSTG-1] * dv_q_reg[DSTG-1];
    assign s6_d_next = Q30_ONE - {1'b0, s6_ss[59:30]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (adv)
            s6_vld_reg <= dv_vld_reg[DSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_d_reg    <= s6_d_next;
            s6_side_reg <= dv_side_reg[DSTG-1];
        end
    end

    // ---------------- cos_t
    logic q2_vld;
    logic [CW-1:0] q2_ct;
    side_t q2_side;

    fdr_isqrt #(.SIDE_W(SIDE_W)) u_sqrt_cos (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(s6_vld_reg), .rad_hi(s6_d_reg), .side_in(s6_side_reg),
        .out_valid(q2_vld), .root(q2_ct), .side_out(q2_side)
    );

    // ---------------- stage 7: index * cosine products, Q28
    logic [NW-1:0] s7_pxs, s7_pys, s7_pxp, s7_pyp;
    logic [XW-1:0] s7_xs_reg, s7_ys_reg, s7_xp_reg, s7_yp_reg;
    logic s7_tir_reg, s7_vld_reg;

    assign s7_pxs = q2_side.et * q2_side.c;
    assign s7_pys = q2_side.ei * q2_ct;
    assign s7_pxp = q2_side.ei * q2_side.c;
    assign s7_pyp = q2_side.et * q2_ct;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (adv)
            s7_vld_reg <= q2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_xs_reg  <= s7_pxs[45:14];
            s7_ys_reg  <= s7_pys[45:14];
            s7_xp_reg  <= s7_pxp[45:14];
            s7_yp_reg  <= s7_pyp[45:14];
            s7_tir_reg <= q2_side.tir;
        end
    end

    // ---------------- stage 8: numerators and denominators
    logic [XW-1:0] s8_ns_reg, s8_np_reg;
    logic [XW:0]   s8_ds_reg, s8_dp_reg;
    logic s8_zs_reg, s8_zp_reg, s8_tir_reg, s8_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_vld_reg <= 1'b0;
        else if (adv)
            s8_vld_reg <= s7_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_ns_reg  <= (s7_xs_reg > s7_ys_reg) ? s7_xs_reg - s7_ys_reg
                                                  : s7_ys_reg - s7_xs_reg;
            s8_np_reg  <= (s7_xp_reg > s7_yp_reg) ? s7_xp_reg - s7_yp_reg
                                                  : s7_yp_reg - s7_xp_reg;
            s8_ds_reg  <= {1'b0, s7_xs_reg} + {1'b0, s7_ys_reg};
            s8_dp_reg  <= {1'b0, s7_xp_reg} + {1'b0, s7_yp_reg};
            s8_zs_reg  <= (s7_xs_reg == '0) && (s7_ys_reg == '0);
            s8_zp_reg  <= (s7_xp_reg == '0) && (s7_yp_reg == '0);
            s8_tir_reg <= s7_tir_reg;
        end
    end

    // ---------------- ratio dividers, s and p lanes side by side
    logic [RSTG-1:0] rt_vld_reg, rt_tir_reg, rt_zs_reg, rt_zp_reg;
    logic [RW-1:0]   rt_rs_reg [RSTG];
    logic [RW-1:0]   rt_rp_reg [RSTG];
    logic [XW:0]     rt_ds_reg [RSTG];
    logic [XW:0]     rt_dp_reg [RSTG];
    logic [CW-1:0]   rt_qs_reg [RSTG];
    logic [CW-1:0]   rt_qp_reg [RSTG];

    for (j = 0; j < RSTG; j++) begin : g_rat
        localparam int K = RSTG - 1 - j;
        localparam logic [CW-1:0] Q_BIT = {{(CW-1){1'b0}}, 1'b1} << K;

        logic [RW-1:0] rs_in, rp_in, dks, dkp, rs_next, rp_next;
        logic [XW:0]   ds_in, dp_in;
        logic [CW-1:0] qs_in, qp_in, qs_next, qp_next;
        logic          v_in, t_in, zs_in, zp_in;

        if (j == 0) begin : g_first
            assign rs_in = {2'b0, s8_ns_reg, 30'b0};
            assign rp_in = {2'b0, s8_np_reg, 30'b0};
            assign ds_in = s8_ds_reg;
            assign dp_in = s8_dp_reg;
            assign qs_in = '0;
            assign qp_in = '0;
            assign v_in  = s8_vld_reg;
            assign t_in  = s8_tir_reg;
            assign zs_in = s8_zs_reg;
            assign zp_in = s8_zp_reg;
        end else begin : g_rest
            assign rs_in = rt_rs_reg[j-1];
            assign rp_in = rt_rp_reg[j-1];
            assign ds_in = rt_ds_reg[j-1];
            assign dp_in = rt_dp_reg[j-1];
            assign qs_in = rt_qs_reg[j-1];
            assign qp_in = rt_qp_reg[j-1];
            assign v_in  = rt_vld_reg[j-1];
            assign t_in  = rt_tir_reg[j-1];
            assign zs_in = rt_zs_reg[j-1];
            assign zp_in = rt_zp_reg[j-1];
        end

        assign dks = {{(RW-XW-1){1'b0}}, ds_in} << K;
        assign dkp = {{(RW-XW-1){1'b0}}, dp_in} << K;

        always_comb
        begin
            if (rs_in >= dks)
            begin
                rs_next = rs_in - dks;
                qs_next = qs_in | Q_BIT;
            end
            else
            begin
                rs_next = rs_in;
                qs_next = qs_in;
            end
            if (rp_in >= dkp)
            begin
                rp_next = rp_in - dkp;
                qp_next = qp_in | Q_BIT;
            end
            else
            begin
                rp_next = rp_in;
                qp_next = qp_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_vld_reg[j] <= 1'b0;
            else if (adv)
                rt_vld_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_rs_reg[j]  <= rs_next;
                rt_rp_reg[j]  <= rp_next;
                rt_ds_reg[j]  <= ds_in;
                rt_dp_reg[j]  <= dp_in;
                rt_qs_reg[j]  <= qs_next;
                rt_qp_reg[j]  <= qp_next;
                rt_tir_reg[j] <= t_in;
                rt_zs_reg[j]  <= zs_in;
                rt_zp_reg[j]  <= zp_in;
            end
        end
    end

    // ---------------- stage 9: square the ratios
    logic [CW-1:0] s9_rs, s9_rp;
    logic [61:0]   s9_ps, s9_pp;
    logic [CW-1:0] s9_rs2_reg, s9_rp2_reg;
    logic s9_tir_reg, s9_vld_reg;

    // an empty denominator counts as a ratio of one
    assign s9_rs = rt_zs_reg[RSTG-1] ? Q30_ONE : rt_qs_reg[RSTG-1];
    assign s9_rp = rt_zp_reg[RSTG-1] ? Q30_ONE : rt_qp_reg[RSTG-1];
    assign s9_ps = s9_rs * s9_rs;
    assign s9_pp = s9_rp * s9_rp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_vld_reg <= 1'b0;
        else if (adv)
            s9_vld_reg <= rt_vld_reg[RSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_rs2_reg <= s9_ps[60:30];
            s9_rp2_reg <= s9_pp[60:30];
            s9_tir_reg <= rt_tir_reg[RSTG-1];
        end
    end

    // ---------------- output: mean, round to Q15, saturate, full on total internal reflection
    logic [CW:0]  o_sum;
    logic [31:0]  o_rnd;
    logic [16:0]  o_q15;
    logic [15:0]  reflectance_next;

    always_comb
    begin
        o_sum = {1'b0, s9_rs2_reg} + {1'b0, s9_rp2_reg};
        o_rnd = {1'b0, o_sum[CW:1]} + 32'h0000_4000;
        o_q15 = o_rnd[31:15];
        if (s9_tir_reg)
            reflectance_next = OUT_ONE;
        else if (o_q15 > {1'b0, OUT_ONE})
            reflectance_next = OUT_ONE;
        else
            reflectance_next = o_q15[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s9_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reflectance_reg    <= reflectance_next;
            total_internal_reg <= s9_tir_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reflectance    = reflectance_reg;
    assign total_internal = total_internal_reg;

    // ---------------- checks
    a_tir_full : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && total_internal |-> reflectance == OUT_ONE)
        else $error("total internal reflection without full reflectance");

    a_refl_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reflectance <= OUT_ONE)
        else $error("reflectance above one");

    a_hold_front : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(s1_vld_reg) && $stable(s9_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

// ----- sv/fdr_isqrt.sv -----
// Pipelined floor square root of (rad_hi << 30), one root bit per stage.
// Depends on fdr_pkg; carries an opaque side band alongside each item.
module fdr_isqrt #(
    parameter int SIDE_W = fdr_pkg::SIDE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [fdr_pkg::CW-1:0]   rad_hi,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic [fdr_pkg::CW-1:0]   root,
    output logic [SIDE_W-1:0]        side_out
);
    import fdr_pkg::*;

    localparam int NSTG = CW;

    logic [NSTG-1:0] vld_reg;
    logic [SQW-1:0]  rem_reg  [NSTG];
    logic [CW-1:0]   root_reg [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];

    genvar j;
    for (j = 0; j < NSTG; j++) begin : g_stg
        localparam int K = NSTG - 1 - j;
        localparam logic [SQW:0]  SQ_BIT = {{SQW{1'b0}}, 1'b1} << (2 * K);
        localparam logic [CW-1:0] R_BIT  = {{(CW-1){1'b0}}, 1'b1} << K;

        logic [SQW-1:0]    rem_in;
        logic [CW-1:0]     root_in;
        logic              v_in;
        logic [SIDE_W-1:0] s_in;
        logic [SQW:0]      cand;
        logic [SQW-1:0]    rem_next;
        logic [CW-1:0]     root_next;

        if (j == 0) begin : g_first
            assign rem_in  = {rad_hi, {(SQW-CW){1'b0}}};
            assign root_in = '0;
            assign v_in    = in_valid;
            assign s_in    = side_in;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign v_in    = vld_reg[j-1];
            assign s_in    = side_reg[j-1];
        end

        // (r + 2^K)^2 - r^2 = (r << (K+1)) + 2^(2K)
        assign cand = ({{(SQW+1-CW){1'b0}}, root_in} << (K + 1)) + SQ_BIT;

        always_comb
        begin
            if ({1'b0, rem_in} >= cand)
            begin
                rem_next  = rem_in - cand[SQW-1:0];
                root_next = root_in | R_BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (adv)
                vld_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign root      = root_reg[NSTG-1];
    assign side_out  = side_reg[NSTG-1];

endmodule
